// ===== src/pob_pkg.sv =====
package pob_pkg;

  // Fixed-point formats and constants
  localparam int FRAC      = 12;
  localparam int AXIS_FRAC = 14;
  localparam int MARGIN    = 41;
  localparam int BIAS      = 1;
  localparam int ONE       = 4096;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER = 3'd0,
    REG_AXIS_U = 3'd1,
    REG_AXIS_V = 3'd2,
    REG_AXIS_W = 3'd3,
    REG_HALF   = 3'd4,
    REG_REST   = 3'd5,
    REG_MODE   = 3'd6
  } cfg_reg_e;

  typedef logic signed [15:0] word_s_t;

  typedef struct packed {
    word_s_t [2:0]       center;
    word_s_t [2:0][2:0]  axis;    // [axis][component]
    logic [2:0][15:0]    half;
    logic [12:0]         rest;
    logic                mode;    // 0 resolve, 1 project
  } cfg_t;

endpackage

// ===== src/pob_if.sv =====
interface pob_in_if #(parameter int CW = 16);
  logic valid;
  logic ready;
  logic signed [CW-1:0] pos_x, pos_y, pos_z;
  logic signed [CW-1:0] vel_x, vel_y, vel_z;
  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

interface pob_out_if #(parameter int CW = 16);
  logic valid;
  logic ready;
  logic signed [CW-1:0] new_pos_x, new_pos_y, new_pos_z;
  logic signed [CW-1:0] new_vel_x, new_vel_y, new_vel_z;
  logic hit;
  modport source (output valid, new_pos_x, new_pos_y, new_pos_z,
                  new_vel_x, new_vel_y, new_vel_z, hit, input ready);
  modport sink (input valid, new_pos_x, new_pos_y, new_pos_z,
                new_vel_x, new_vel_y, new_vel_z, hit, output ready);
endinterface

// ===== src/pob_proj.sv =====
module pob_proj import pob_pkg::*; #(
  parameter int CW = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  cfg_t cfg_i,
  input  logic valid_i,
  input  logic signed [CW-1:0] pos_i [3],
  input  logic signed [CW-1:0] vel_i [3],
  output logic valid_o,
  output logic signed [CW-1:0] pos_o [3],
  output logic signed [CW-1:0] vel_o [3],
  output logic signed [((CW > 16) ? CW : 16) + 5 : 0] l_o [3],
  output logic signed [CW+4:0] vr_o [3]
);

  localparam int MW  = (CW > 16) ? CW : 16;
  localparam int DW  = MW + 1;
  localparam int PW  = DW + 16;
  localparam int SW  = PW + 2;
  localparam int LW  = DW + 5;
  localparam int VPW = CW + 16;
  localparam int VSW = CW + 18;
  localparam int VRW = CW + 5;

  logic                 v1_q, v2_q, v3_q;
  logic signed [DW-1:0] d_q   [3];
  logic signed [CW-1:0] pos1_q [3], vel1_q [3], pos2_q [3], vel2_q [3];
  logic signed [PW-1:0] pd_q  [3][3];
  logic signed [VPW-1:0] pv_q [3][3];
  logic signed [SW:0]   lsum  [3];
  logic signed [VSW:0]  vsum  [3];

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage 1: offset from center
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        d_q[i]    <= DW'(pos_i[i]) - DW'(cfg_i.center[i]);
        pos1_q[i] <= pos_i[i];
        vel1_q[i] <= vel_i[i];
      end
    end
  end

  // Stage 2: per-axis products of offset and velocity
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          pd_q[k][i] <= PW'(d_q[i]) * PW'(cfg_i.axis[k][i]);
          pv_q[k][i] <= VPW'(vel1_q[i]) * VPW'(cfg_i.axis[k][i]);
        end
      end
      pos2_q <= pos1_q;
      vel2_q <= vel1_q;
    end
  end

  // Stage 3: sum and round the projections
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lsum[k] = (SW+1)'(pd_q[k][0]) + (SW+1)'(pd_q[k][1]) + (SW+1)'(pd_q[k][2])
              + (SW+1)'(1 <<< (AXIS_FRAC - 1));
      vsum[k] = (VSW+1)'(pv_q[k][0]) + (VSW+1)'(pv_q[k][1]) + (VSW+1)'(pv_q[k][2])
              + (VSW+1)'(1 <<< (AXIS_FRAC - 1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        l_o[k]  <= LW'(lsum[k] >>> AXIS_FRAC);
        vr_o[k] <= VRW'(vsum[k] >>> AXIS_FRAC);
      end
      pos_o <= pos2_q;
      vel_o <= vel2_q;
    end
  end

  assign valid_o = v3_q;

endmodule

// ===== src/pob_push.sv =====
module pob_push import pob_pkg::*; #(
  parameter int CW = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  cfg_t cfg_i,
  input  logic valid_i,
  input  logic signed [CW-1:0] pos_i [3],
  input  logic signed [CW-1:0] vel_i [3],
  input  logic signed [((CW > 16) ? CW : 16) + 5 : 0] l_i [3],
  input  logic signed [CW+4:0] vr_i [3],
  output logic valid_o,
  output logic signed [CW-1:0] pos_o [3],
  output logic signed [CW-1:0] vel_o [3],
  output logic hit_o
);

  localparam int MW   = (CW > 16) ? CW : 16;
  localparam int LW   = MW + 7;
  localparam int PENW = LW + 2;
  localparam int DSW  = 18;
  localparam int AXW  = 17;
  localparam int PPW  = AXW + DSW;
  localparam int VDW  = CW + 6;
  localparam int SPW  = VDW + 15;
  localparam int SCW  = CW + 10;
  localparam int VQW  = AXW + SCW;
  localparam int NPW  = CW + 23;

  typedef struct packed {
    logic hit;
    logic vneg;
  } flag_t;

  function automatic logic signed [CW-1:0] sat(input logic signed [NPW-1:0] x);
    logic signed [NPW-1:0] hi;
    logic signed [NPW-1:0] lo;
    hi = NPW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    lo = -NPW'(64'sd1 <<< (CW - 1));
    if (x > hi) return CW'(hi);
    if (x < lo) return CW'(lo);
    return CW'(x);
  endfunction

  logic                    v4_q, v5_q, v6_q, v7_q, v8_q;
  flag_t                   f4_q, f5_q, f6_q, f7_q;
  logic signed [CW-1:0]    pos4_q [3], pos5_q [3], vel4_q [3], vel5_q [3], vel6_q [3];
  logic signed [CW-1:0]    vel7_q [3];
  logic signed [AXW-1:0]   ax4_q [3], ax5_q [3], ax6_q [3];
  logic signed [DSW-1:0]   dist4_q;
  logic signed [VDW-1:0]   vd4_q;
  logic signed [PPW-1:0]   pp5_q [3];
  logic signed [SPW-1:0]   sp5_q;
  logic signed [NPW-1:0]   np6_q [3], np7_q [3];
  logic signed [SCW-1:0]   sc6_q;
  logic signed [VQW-1:0]   vq7_q [3];

  // Stage 4 combinational: inside test, face choice
  logic signed [LW-1:0]   al [3];
  logic signed [PENW-1:0] hh [3], pen [3];
  logic                   in_box, sgn_pos;
  logic [1:0]             a_sel;
  logic signed [VDW-1:0]  vr_sel;
  logic signed [VDW-1:0]  vd;
  logic signed [PENW-1:0] dist_w;

  always_comb begin
    in_box = 1'b1;
    for (int k = 0; k < 3; k++) begin
      al[k]  = (l_i[k] < 0) ? -LW'(l_i[k]) : LW'(l_i[k]);
      hh[k]  = PENW'({1'b0, cfg_i.half[k]})
             + ((cfg_i.mode == 1'b0) ? PENW'(MARGIN) : PENW'(0));
      pen[k] = hh[k] - PENW'(al[k]);
      if (PENW'(al[k]) >= hh[k]) in_box = 1'b0;
    end
    if (pen[0] <= pen[1] && pen[0] <= pen[2]) a_sel = 2'd0;
    else if (pen[1] <= pen[2])                a_sel = 2'd1;
    else                                      a_sel = 2'd2;
    sgn_pos = (l_i[a_sel] >= 0);
    vr_sel  = VDW'(vr_i[a_sel]);
    vd      = sgn_pos ? vr_sel : -vr_sel;
    dist_w  = pen[a_sel] + PENW'(BIAS);
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= valid_i;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Stage 4: hold choice, signed axis, push distance
      f4_q.hit  <= in_box;
      f4_q.vneg <= (vd < 0);
      for (int i = 0; i < 3; i++) begin
        ax4_q[i] <= sgn_pos ? AXW'(cfg_i.axis[a_sel][i]) : -AXW'(cfg_i.axis[a_sel][i]);
      end
      dist4_q <= DSW'(dist_w);
      vd4_q   <= vd;
      pos4_q  <= pos_i;
      vel4_q  <= vel_i;

      // Stage 5: push and bounce products
      for (int i = 0; i < 3; i++) begin
        pp5_q[i] <= PPW'(ax4_q[i]) * PPW'(dist4_q);
      end
      sp5_q  <= SPW'($signed({1'b0, 14'(ONE) + 14'(cfg_i.rest)})) * SPW'(vd4_q);
      f5_q   <= f4_q;
      ax5_q  <= ax4_q;
      pos5_q <= pos4_q;
      vel5_q <= vel4_q;

      // Stage 6: round, move position, scale velocity
      for (int i = 0; i < 3; i++) begin
        np6_q[i] <= f5_q.hit
          ? NPW'(pos5_q[i]) + NPW'(((PPW+1)'(pp5_q[i]) + (PPW+1)'(1 <<< (AXIS_FRAC - 1)))
                                   >>> AXIS_FRAC)
          : NPW'(pos5_q[i]);
      end
      sc6_q  <= SCW'(((SPW+1)'(sp5_q) + (SPW+1)'(1 <<< (FRAC - 1))) >>> FRAC);
      f6_q   <= f5_q;
      ax6_q  <= ax5_q;
      vel6_q <= vel5_q;

      // Stage 7: reflection products
      for (int i = 0; i < 3; i++) begin
        vq7_q[i] <= VQW'(ax6_q[i]) * VQW'(sc6_q);
      end
      np7_q  <= np6_q;
      f7_q   <= f6_q;
      vel7_q <= vel6_q;

      // Stage 8: reflect velocity, saturate into output register
      for (int i = 0; i < 3; i++) begin
        pos_o[i] <= sat(np7_q[i]);
        vel_o[i] <= (f7_q.hit && f7_q.vneg && cfg_i.mode == 1'b0)
          ? sat(NPW'(vel7_q[i]) - NPW'(((VQW+1)'(vq7_q[i])
                + (VQW+1)'(1 <<< (AXIS_FRAC - 1))) >>> AXIS_FRAC))
          : vel7_q[i];
      end
      hit_o <= f7_q.hit;
    end
  end

  assign valid_o = v8_q;

endmodule

// ===== src/point_obb_collision_resolve_top.sv =====
// Channel  Dir  Payload                                        Transfer
// in_i     in   pos_x/y/z, vel_x/y/z                           valid & ready
// out_o    out  new_pos_x/y/z, new_vel_x/y/z, hit              valid & ready
// cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i                cfg_we_i
//
// One item per cycle while the output does not stall, through eight register stages
// (offset, products, projection sums, face choice, push products, position
// update, reflection products, output register).
// Reset clears all configuration registers and valid bits.
// A stall at the output freezes every stage at once; ready is low only while
// the output register holds an untaken result.
module point_obb_collision_resolve_top import pob_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  pob_in_if.sink                in_i,
  pob_out_if.source             out_o
);

  localparam int CW = COORD_WIDTH;
  localparam int MW = (CW > 16) ? CW : 16;

  cfg_t cfg_q;
  logic en;
  logic p_valid, o_valid, o_hit;
  logic signed [CW-1:0] in_pos [3], in_vel [3];
  logic signed [CW-1:0] p_pos [3], p_vel [3], o_pos [3], o_vel [3];
  logic signed [MW+5:0] p_l [3];
  logic signed [CW+4:0] p_vr [3];

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CENTER: cfg_q.center  <= cfg_data_i;
        REG_AXIS_U: cfg_q.axis[0] <= cfg_data_i;
        REG_AXIS_V: cfg_q.axis[1] <= cfg_data_i;
        REG_AXIS_W: cfg_q.axis[2] <= cfg_data_i;
        REG_HALF:   cfg_q.half    <= cfg_data_i;
        REG_REST:   cfg_q.rest    <= cfg_data_i[12:0];
        REG_MODE:   cfg_q.mode    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Advance the whole pipeline unless the output holds
  assign en         = !o_valid || out_o.ready;
  assign in_i.ready = en;

  assign in_pos[0] = in_i.pos_x;
  assign in_pos[1] = in_i.pos_y;
  assign in_pos[2] = in_i.pos_z;
  assign in_vel[0] = in_i.vel_x;
  assign in_vel[1] = in_i.vel_y;
  assign in_vel[2] = in_i.vel_z;

  pob_proj #(.CW(CW)) u_proj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .valid_i (in_i.valid),
    .pos_i   (in_pos),
    .vel_i   (in_vel),
    .valid_o (p_valid),
    .pos_o   (p_pos),
    .vel_o   (p_vel),
    .l_o     (p_l),
    .vr_o    (p_vr)
  );

  pob_push #(.CW(CW)) u_push (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .valid_i (p_valid),
    .pos_i   (p_pos),
    .vel_i   (p_vel),
    .l_i     (p_l),
    .vr_i    (p_vr),
    .valid_o (o_valid),
    .pos_o   (o_pos),
    .vel_o   (o_vel),
    .hit_o   (o_hit)
  );

  assign out_o.valid     = o_valid;
  assign out_o.new_pos_x = o_pos[0];
  assign out_o.new_pos_y = o_pos[1];
  assign out_o.new_pos_z = o_pos[2];
  assign out_o.new_vel_x = o_vel[0];
  assign out_o.new_vel_y = o_vel[1];
  assign out_o.new_vel_z = o_vel[2];
  assign out_o.hit       = o_hit;

endmodule
